// ----- hw/rtl/gss_pkg.sv -----
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants of the gearshift sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gss_pkg;

  localparam int unsigned MsW     = 16;
  localparam int unsigned PulseW  = 12;
  localparam int unsigned LeverW  = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  // input commands
  localparam logic [CmdW-1:0] CmdTick = 2'd0;
  localparam logic [CmdW-1:0] CmdUp   = 2'd1;
  localparam logic [CmdW-1:0] CmdDown = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegUpDelay    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDownDelay  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSolOn      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegClutchIn   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegClutchOut  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSettle     = 3'd6;

  // register reset values
  localparam logic [MsW-1:0]    UpDelayRst   = 16'd50;
  localparam logic [MsW-1:0]    DownDelayRst = 16'd100;
  localparam logic [MsW-1:0]    SolOnRst     = 16'd80;
  localparam logic [PulseW-1:0] ClutchInRst  = 12'd2000;
  localparam logic [PulseW-1:0] ClutchOutRst = 12'd1000;
  localparam logic [LeverW-1:0] ThresholdRst = 8'd90;
  localparam logic [MsW-1:0]    SettleRst    = 16'd50;

  localparam logic [MsW-1:0] MsMax = {MsW{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SPARK_CUT  = 3'd1,
    PH_UP_ON      = 3'd2,
    PH_UP_OFF     = 3'd3,
    PH_CLUTCH_IN  = 3'd4,
    PH_DOWN_ON    = 3'd5,
    PH_DOWN_OFF   = 3'd6,
    PH_CLUTCH_OUT = 3'd7
  } phase_e;

  typedef struct packed {
    logic              ecu_enable;
    logic              up_solenoid;
    logic              down_solenoid;
    logic              indicator;
    logic              clutch_write;
    logic [PulseW-1:0] clutch_pulse_us;
    logic              clutch_follows_driver;
    logic              shift_notice;
    logic              shift_rejected;
    logic [2:0]        phase;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    wdata;
  } cfg_wr_t;

endpackage

// ----- hw/rtl/gear_shift_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// gear_shift_sequencer_top
// Gearshift sequencer: one item per tick or shift request, one result each.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tuser: command, tdata: clutch_position
//  m_axis    out  tvalid/tready         tdata: result fields
//  cfg       in   cfg_we_i              cfg_idx_i, cfg_wdata_i
//
//  One item per cycle while tready is high; its result is registered, in the
//  result register or, under output stall, in the skid. The two-entry output
//  buffer takes one more item while the output stalls; tready drops once full.
//  Reset loads the register defaults and puts the sequencer idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gear_shift_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] clutch_position
  input  logic [gss_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] command
  input  logic [gss_pkg::CmdW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] ecu_enable, [1] up_solenoid, [2] down_solenoid, [3] indicator,
  // [4] clutch_write, [16:5] clutch_pulse_us, [17] clutch_follows_driver,
  // [18] shift_notice, [19] shift_rejected, [22:20] phase, [23] zero
  output logic [gss_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [gss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gss_pkg::CfgW-1:0]      cfg_wdata_i
);
  import gss_pkg::*;

  cfg_wr_t cfg;
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    s_acc, m_take;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  assign s_axis_tready = !skid_valid_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_take        = out_valid_q && m_axis_tready;

  gss_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_en_i (s_acc),
    .cmd_i     (s_axis_tuser),
    .lever_i   (s_axis_tdata[LeverW-1:0]),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (m_take) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= s_acc;
        end
      end else if (s_acc) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_take) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (s_acc) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.phase, out_q.shift_rejected, out_q.shift_notice,
                          out_q.clutch_follows_driver, out_q.clutch_pulse_us,
                          out_q.clutch_write, out_q.indicator, out_q.down_solenoid,
                          out_q.up_solenoid, out_q.ecu_enable};

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item ahead of the result register");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("item accepted under stall not kept in skid");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_take && !s_acc && !skid_valid_q) |=> !out_valid_q)
    else $error("result offered twice");

endmodule

// ----- hw/rtl/gss_core.sv -----
// ----------------------------------------------------------------------------
// gss_core
// Shift phase state, configuration registers and the per-item update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gss_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gss_pkg::cfg_wr_t        cfg_i,
  input  logic                    item_en_i,
  input  logic [gss_pkg::CmdW-1:0]   cmd_i,
  input  logic [gss_pkg::LeverW-1:0] lever_i,
  output gss_pkg::result_t        result_o
);
  import gss_pkg::*;

  logic [MsW-1:0]    up_delay_q, down_delay_q, sol_on_q, settle_q;
  logic [PulseW-1:0] clutch_in_q, clutch_out_q;
  logic [LeverW-1:0] threshold_q;

  phase_e         phase_q, phase_d;
  logic [MsW-1:0] elapsed_q, elapsed_d;
  logic           entry_q, entry_d;
  logic           ecu_q, ecu_d;
  logic           up_q, up_d;
  logic           down_q, down_d;
  logic           follow_q, follow_d;

  logic              lever_in;
  logic              first;
  logic [MsW-1:0]    el_inc;
  logic              cwrite, notice, reject;
  logic [PulseW-1:0] pulse;
  logic [MsW-1:0]    wait_ms;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    entry_d   = entry_q;
    ecu_d     = ecu_q;
    up_d      = up_q;
    down_d    = down_q;
    follow_d  = follow_q;
    cwrite    = 1'b0;
    notice    = 1'b0;
    reject    = 1'b0;
    pulse     = '0;
    lever_in  = (lever_i >= threshold_q);
    el_inc    = (elapsed_q < MsMax) ? elapsed_q + 16'd1 : elapsed_q;
    first     = !entry_q;
    wait_ms   = lever_in ? up_delay_q : down_delay_q;

    unique case (cmd_i)
      CmdUp, CmdDown: begin
        if (phase_q != PH_IDLE && phase_q != PH_CLUTCH_OUT) begin
          reject = 1'b1;
        end else begin
          // a request in clutch out drops the pending release
          notice    = 1'b1;
          phase_d   = (cmd_i == CmdUp) ? PH_SPARK_CUT : PH_CLUTCH_IN;
          elapsed_d = '0;
          entry_d   = 1'b0;
        end
      end
      CmdTick: begin
        elapsed_d = el_inc;
        entry_d   = 1'b1;
        unique case (phase_q)
          PH_SPARK_CUT: begin
            if (first) ecu_d = 1'b0;
            if (el_inc >= up_delay_q) phase_d = PH_UP_ON;
          end
          PH_UP_ON: begin
            if (first) up_d = 1'b1;
            if (el_inc >= sol_on_q) phase_d = PH_UP_OFF;
          end
          PH_UP_OFF: begin
            if (first) begin
              up_d  = 1'b0;
              ecu_d = 1'b1;
            end
            phase_d = PH_IDLE;
          end
          PH_CLUTCH_IN: begin
            if (first) begin
              follow_d = 1'b0;
              cwrite   = 1'b1;
              pulse    = clutch_in_q;
            end
            if (el_inc >= wait_ms) phase_d = PH_DOWN_ON;
          end
          PH_DOWN_ON: begin
            if (first) down_d = 1'b1;
            if (el_inc >= sol_on_q) phase_d = PH_DOWN_OFF;
          end
          PH_DOWN_OFF: begin
            if (first) down_d = 1'b0;
            if (lever_in) begin
              follow_d = 1'b1;
              phase_d  = PH_IDLE;
            end else if (el_inc >= settle_q) begin
              phase_d = PH_CLUTCH_OUT;
            end
          end
          PH_CLUTCH_OUT: begin
            if (first) begin
              cwrite   = 1'b1;
              pulse    = clutch_out_q;
              follow_d = 1'b1;
            end
            phase_d = PH_IDLE;
          end
          default: ;
        endcase
        // every phase change restarts the timer and the entry action
        if (phase_d != phase_q) begin
          elapsed_d = '0;
          entry_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.ecu_enable            = ecu_d;
    result_o.up_solenoid           = up_d;
    result_o.down_solenoid         = down_d;
    result_o.indicator             = up_d | down_d;
    result_o.clutch_write          = cwrite;
    result_o.clutch_pulse_us       = pulse;
    result_o.clutch_follows_driver = follow_d;
    result_o.shift_notice          = notice;
    result_o.shift_rejected        = reject;
    result_o.phase                 = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      entry_q   <= 1'b0;
      ecu_q     <= 1'b1;
      up_q      <= 1'b0;
      down_q    <= 1'b0;
      follow_q  <= 1'b1;
    end else if (item_en_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      entry_q   <= entry_d;
      ecu_q     <= ecu_d;
      up_q      <= up_d;
      down_q    <= down_d;
      follow_q  <= follow_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_delay_q   <= UpDelayRst;
      down_delay_q <= DownDelayRst;
      sol_on_q     <= SolOnRst;
      clutch_in_q  <= ClutchInRst;
      clutch_out_q <= ClutchOutRst;
      threshold_q  <= ThresholdRst;
      settle_q     <= SettleRst;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        RegUpDelay:   up_delay_q   <= cfg_i.wdata;
        RegDownDelay: down_delay_q <= cfg_i.wdata;
        RegSolOn:     sol_on_q     <= cfg_i.wdata;
        RegClutchIn:  clutch_in_q  <= cfg_i.wdata[PulseW-1:0];
        RegClutchOut: clutch_out_q <= cfg_i.wdata[PulseW-1:0];
        RegThreshold: threshold_q  <= cfg_i.wdata[LeverW-1:0];
        RegSettle:    settle_q     <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  a_entry_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != $past(phase_q)) |-> !entry_q)
    else $error("entry flag not cleared on phase change");

  a_up_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_q |-> (phase_q == PH_UP_ON || phase_q == PH_UP_OFF))
    else $error("up solenoid driven outside upshift");

  a_down_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    down_q |-> (phase_q == PH_DOWN_ON || phase_q == PH_DOWN_OFF))
    else $error("down solenoid driven outside downshift");

  a_spark_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ecu_q |-> (phase_q == PH_SPARK_CUT || phase_q == PH_UP_ON || phase_q == PH_UP_OFF))
    else $error("ignition cut outside upshift");

endmodule

// ----- test/gear_shift_sequencer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear_shift_sequencer_top_tb
// Self-checking bench for the gearshift sequencer. A short table of directed
// items walks both shift kinds, refusals and the clutch-held restart; random
// items under several register settings follow, plus one longer spark-cut
// run. Every output item is checked field by field against an in-bench model
// of the sequencer or a directed row's expected result, with bursty input and a stalling output.
// ----------------------------------------------------------------------------

module gear_shift_sequencer_top_tb;
  import gss_pkg::*;

  localparam logic [CmdW-1:0]    CmdUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] RegNone    = 3'd7;
  localparam int unsigned        CycleLimit = 6_000_000;
  localparam int unsigned        ReportMax  = 40;
  localparam int unsigned        LongTicks  = 30;

  // laid out as m_axis_tdata, top bit first
  typedef struct packed {
    logic              pad;
    logic [2:0]        phase;
    logic              rejected;
    logic              notice;
    logic              follows;
    logic [PulseW-1:0] pulse;
    logic              clutch_wr;
    logic              indicator;
    logic              down_sol;
    logic              up_sol;
    logic              ecu_en;
  } shift_out_t;

  typedef struct {
    bit                  is_cfg;
    logic [CmdW-1:0]     cmd;
    logic [LeverW-1:0]   lever;
    logic [CfgIdxW-1:0]  ridx;
    logic [CfgW-1:0]     rval;
    bit                  typed;
    shift_out_t          want;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;

  gear_shift_sequencer_top u_top (.*);

  always #5 clk_i = ~clk_i;

  // sequencer model state
  phase_e            ph_q;
  logic [MsW-1:0]    elapsed_q;
  bit                entered_q, ecu_q, up_q, down_q, follow_q;
  logic [MsW-1:0]    up_delay_q, down_delay_q, sol_on_q, settle_q;
  logic [PulseW-1:0] pulse_in_q, pulse_out_q;
  logic [LeverW-1:0] thresh_q;

  shift_out_t  awaited_outputs[$];
  stim_row_t   stim_tbl[$];
  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  logic [7:0]  rx_phase = '0;

  function automatic void seq_reset();
    ph_q = PH_IDLE; elapsed_q = '0; entered_q = 1'b0;
    ecu_q = 1'b1; up_q = 1'b0; down_q = 1'b0; follow_q = 1'b1;
    up_delay_q = UpDelayRst; down_delay_q = DownDelayRst; sol_on_q = SolOnRst;
    pulse_in_q = ClutchInRst; pulse_out_q = ClutchOutRst;
    thresh_q = ThresholdRst; settle_q = SettleRst;
  endfunction

  function automatic void seq_config(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    case (idx)
      RegUpDelay:   up_delay_q   = val;
      RegDownDelay: down_delay_q = val;
      RegSolOn:     sol_on_q     = val;
      RegClutchIn:  pulse_in_q   = val[PulseW-1:0];
      RegClutchOut: pulse_out_q  = val[PulseW-1:0];
      RegThreshold: thresh_q     = val[LeverW-1:0];
      RegSettle:    settle_q     = val;
      default: ;
    endcase
  endfunction

  function automatic void enter_phase(phase_e p);
    ph_q = p;
    elapsed_q = '0;
    entered_q = 1'b0;
  endfunction

  function automatic void advance_after(logic [MsW-1:0] delay_ms, phase_e p);
    if (elapsed_q >= delay_ms) enter_phase(p);
  endfunction

  function automatic shift_out_t sequencer_step(logic [CmdW-1:0] cmd,
                                                logic [LeverW-1:0] lever);
    shift_out_t o;
    bit         lever_in;
    bit         first;
    o = '0;
    lever_in = (lever >= thresh_q);
    if (cmd == CmdUp || cmd == CmdDown) begin
      if (ph_q != PH_IDLE && ph_q != PH_CLUTCH_OUT) begin
        o.rejected = 1'b1;
      end else begin
        o.notice = 1'b1;
        // a restart from clutch out skips the clutch release
        enter_phase(cmd == CmdUp ? PH_SPARK_CUT : PH_CLUTCH_IN);
      end
    end else if (cmd == CmdTick) begin
      if (elapsed_q != MsMax) elapsed_q++;
      first = !entered_q;
      entered_q = 1'b1;
      case (ph_q)
        PH_SPARK_CUT: begin
          if (first) ecu_q = 1'b0;
          advance_after(up_delay_q, PH_UP_ON);
        end
        PH_UP_ON: begin
          if (first) up_q = 1'b1;
          advance_after(sol_on_q, PH_UP_OFF);
        end
        PH_UP_OFF: begin
          if (first) begin
            up_q = 1'b0;
            ecu_q = 1'b1;
          end
          enter_phase(PH_IDLE);
        end
        PH_CLUTCH_IN: begin
          if (first) begin
            follow_q = 1'b0;
            o.clutch_wr = 1'b1;
            o.pulse = pulse_in_q;
          end
          // lever already in: short wait
          advance_after(lever_in ? up_delay_q : down_delay_q, PH_DOWN_ON);
        end
        PH_DOWN_ON: begin
          if (first) down_q = 1'b1;
          advance_after(sol_on_q, PH_DOWN_OFF);
        end
        PH_DOWN_OFF: begin
          if (first) down_q = 1'b0;
          if (lever_in) begin
            follow_q = 1'b1;
            enter_phase(PH_IDLE);
          end else begin
            advance_after(settle_q, PH_CLUTCH_OUT);
          end
        end
        PH_CLUTCH_OUT: begin
          if (first) begin
            o.clutch_wr = 1'b1;
            o.pulse = pulse_out_q;
            follow_q = 1'b1;
          end
          enter_phase(PH_IDLE);
        end
        default: ;
      endcase
    end
    o.ecu_en    = ecu_q;
    o.up_sol    = up_q;
    o.down_sol  = down_q;
    o.indicator = up_q | down_q;
    o.follows   = follow_q;
    o.phase     = ph_q;
    return o;
  endfunction

  function automatic shift_out_t mk_result(bit ecu, bit up, bit dn, bit ind, bit cw,
                                           logic [PulseW-1:0] pulse, bit fol, bit ntc,
                                           bit rej, phase_e p);
    shift_out_t o;
    o = '0;
    o.ecu_en = ecu; o.up_sol = up; o.down_sol = dn; o.indicator = ind;
    o.clutch_wr = cw; o.pulse = pulse; o.follows = fol;
    o.notice = ntc; o.rejected = rej; o.phase = p;
    return o;
  endfunction

  function automatic stim_row_t row_item(logic [CmdW-1:0] c, logic [LeverW-1:0] l);
    stim_row_t r;
    r.is_cfg = 1'b0; r.cmd = c; r.lever = l;
    r.ridx = RegNone; r.rval = '0; r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t row_checked(logic [CmdW-1:0] c, logic [LeverW-1:0] l,
                                            shift_out_t w);
    stim_row_t r;
    r = row_item(c, l);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic stim_row_t row_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    stim_row_t r;
    r = row_item(CmdTick, '0);
    r.is_cfg = 1'b1; r.ridx = idx; r.rval = val;
    return r;
  endfunction

  function automatic void build_table();
    // register defaults after reset
    stim_tbl.push_back(row_checked(CmdTick, 8'd0,
      mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b0, PH_IDLE)));
    stim_tbl.push_back(row_checked(CmdUnused, 8'd255,
      mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b0, PH_IDLE)));
    stim_tbl.push_back(row_checked(CmdUp, 8'd255,
      mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b1, 1'b0, PH_SPARK_CUT)));
    stim_tbl.push_back(row_checked(CmdDown, 8'd0,
      mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b1, PH_SPARK_CUT)));
    stim_tbl.push_back(row_checked(CmdTick, 8'd128,
      mk_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b0, PH_SPARK_CUT)));
    stim_tbl.push_back(row_checked(CmdUp, 8'd0,
      mk_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b1, PH_SPARK_CUT)));
    // short timings, widest clutch-in pulse, threshold at the top
    stim_tbl.push_back(row_reg(RegUpDelay, 16'd1));
    stim_tbl.push_back(row_reg(RegDownDelay, 16'd2));
    stim_tbl.push_back(row_reg(RegSolOn, 16'd1));
    stim_tbl.push_back(row_reg(RegClutchIn, 16'd4095));
    stim_tbl.push_back(row_reg(RegClutchOut, 16'd0));
    stim_tbl.push_back(row_reg(RegThreshold, 16'd255));
    stim_tbl.push_back(row_reg(RegSettle, 16'd1));
    stim_tbl.push_back(row_item(CmdTick, 8'd0));
    stim_tbl.push_back(row_item(CmdTick, 8'd0));
    stim_tbl.push_back(row_item(CmdTick, 8'd0));
    // downshift with lever out, then re-read as in
    stim_tbl.push_back(row_item(CmdDown, 8'd0));
    stim_tbl.push_back(row_checked(CmdTick, 8'd0,
      mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 12'd4095, 1'b0, 1'b0, 1'b0, PH_CLUTCH_IN)));
    stim_tbl.push_back(row_item(CmdTick, 8'd255));
    stim_tbl.push_back(row_item(CmdTick, 8'd0));
    stim_tbl.push_back(row_checked(CmdUp, 8'd0,
      mk_result(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b1, PH_DOWN_OFF)));
    stim_tbl.push_back(row_item(CmdTick, 8'd0));
    // request during clutch out: clutch stays held
    stim_tbl.push_back(row_checked(CmdUp, 8'd0,
      mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b1, 1'b0, PH_SPARK_CUT)));
    stim_tbl.push_back(row_item(CmdTick, 8'd0));
    stim_tbl.push_back(row_item(CmdTick, 8'd0));
    stim_tbl.push_back(row_checked(CmdTick, 8'd0,
      mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, PH_IDLE)));
    // downshift with lever in: straight back to the driver
    stim_tbl.push_back(row_item(CmdDown, 8'd255));
    stim_tbl.push_back(row_item(CmdTick, 8'd255));
    stim_tbl.push_back(row_item(CmdTick, 8'd255));
    stim_tbl.push_back(row_checked(CmdTick, 8'd255,
      mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b0, PH_IDLE)));
  endfunction

  task automatic cmp_field(string name, logic [PulseW-1:0] want, logic [PulseW-1:0] got);
    if (got !== want) begin
      if (fault_cnt < ReportMax)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fault_cnt++;
    end
  endtask

  task automatic check_output(logic [OutDataW-1:0] raw);
    shift_out_t want;
    shift_out_t got;
    got = raw;
    if (awaited_outputs.size() == 0) begin
      if (fault_cnt < ReportMax)
        $display("%0t: output item with none expected, expected none actual %h",
                 $time, raw);
      fault_cnt++;
    end else begin
      want = awaited_outputs.pop_front();
      cmp_field("ecu_enable", PulseW'(want.ecu_en), PulseW'(got.ecu_en));
      cmp_field("up_solenoid", PulseW'(want.up_sol), PulseW'(got.up_sol));
      cmp_field("down_solenoid", PulseW'(want.down_sol), PulseW'(got.down_sol));
      cmp_field("indicator", PulseW'(want.indicator), PulseW'(got.indicator));
      cmp_field("clutch_write", PulseW'(want.clutch_wr), PulseW'(got.clutch_wr));
      cmp_field("clutch_pulse_us", want.pulse, got.pulse);
      cmp_field("clutch_follows_driver", PulseW'(want.follows), PulseW'(got.follows));
      cmp_field("shift_notice", PulseW'(want.notice), PulseW'(got.notice));
      cmp_field("shift_rejected", PulseW'(want.rejected), PulseW'(got.rejected));
      cmp_field("phase", PulseW'(want.phase), PulseW'(got.phase));
      cmp_field("pad", PulseW'(want.pad), PulseW'(got.pad));
    end
  endtask

  // output side: checks accepted items, stalls in changing patterns
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_output(m_axis_tdata);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(32, 256);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      default: m_axis_tready <= (rx_phase[3:0] < 4'd5);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic [CmdW-1:0] cmd, logic [LeverW-1:0] lever, bit typed,
                           shift_out_t want);
    shift_out_t guess;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= lever;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    guess = sequencer_step(cmd, lever);
    awaited_outputs.push_back(typed ? want : guess);
    burst_left--;
  endtask

  // sender stops until every output item is back
  task automatic hold_until_quiet();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (awaited_outputs.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    seq_config(idx, val);
  endtask

  task automatic load_settings(logic [CfgW-1:0] up_ms, logic [CfgW-1:0] down_ms,
                               logic [CfgW-1:0] sol_ms, logic [CfgW-1:0] cin,
                               logic [CfgW-1:0] cout, logic [CfgW-1:0] thr,
                               logic [CfgW-1:0] settle_ms);
    hold_until_quiet();
    write_reg(RegUpDelay, up_ms);
    write_reg(RegDownDelay, down_ms);
    write_reg(RegSolOn, sol_ms);
    write_reg(RegClutchIn, cin);
    write_reg(RegClutchOut, cout);
    write_reg(RegThreshold, thr);
    write_reg(RegSettle, settle_ms);
    write_reg(RegNone, CfgW'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    bit              cfg_open;
    int              pause_at;
    int              roll;
    int              dmax;
    logic [CmdW-1:0] c;
    logic [LeverW-1:0] l;
    cfg_open = 1'b0;
    seq_reset();
    build_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].is_cfg) begin
        if (!cfg_open) begin
          hold_until_quiet();
          cfg_open = 1'b1;
        end
        write_reg(stim_tbl[i].ridx, stim_tbl[i].rval);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(stim_tbl[i].cmd, stim_tbl[i].lever, stim_tbl[i].typed,
                  stim_tbl[i].want);
      end
    end

    // longer spark cut: the phase must advance exactly at the set count
    load_settings(16'd25, 16'd4, 16'd3, 16'd2000, 16'd1000, 16'd90, 16'd2);
    send_item(CmdUp, LeverW'($urandom_range(0, 255)), 1'b0, '0);
    repeat (LongTicks) send_item(CmdTick, LeverW'($urandom_range(0, 255)), 1'b0, '0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_settings('0, '0, '0, '0, '0, '0, '0);
        1: load_settings(16'd2, 16'd5, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4);
        default: begin
          dmax = (p % 2) ? 30 : 6;
          load_settings(CfgW'($urandom_range(0, dmax)), CfgW'($urandom_range(0, dmax)),
                        CfgW'($urandom_range(0, dmax)), CfgW'($urandom_range(0, 65535)),
                        CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)),
                        CfgW'($urandom_range(0, dmax)));
        end
      endcase
      pause_at = $urandom_range(20, 140);
      for (int n = 0; n < 165; n++) begin
        if (n == pause_at) hold_until_quiet();
        roll = $urandom_range(0, 99);
        if (roll < 8)       c = CmdUp;
        else if (roll < 16) c = CmdDown;
        else if (roll < 20) c = CmdUnused;
        else                c = CmdTick;
        // lever often at or just below the threshold
        case ($urandom_range(0, 3))
          0: l = LeverW'($urandom_range(0, 255));
          1: l = thresh_q;
          2: l = thresh_q - 8'd1;
          default: l = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        send_item(c, l, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
